// ===== rtl/esdq_pkg.sv =====
// Shared types and constants for the ellipse scan and pending-cell queue.
// Used by every module of the block; depends on nothing.
package esdq_pkg;

	localparam int CELL_BITS  = 12;
	localparam int CELLS      = 4096;
	localparam int CNT_BITS   = 13;
	localparam int MUL_BITS   = 10;
	localparam int PROD_BITS  = 20;
	localparam logic [6:0] GRID_MAX = 7'd64;
	localparam logic [CELL_BITS-1:0] LAST_CELL = 12'hFFF;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_D_RX,
		ST_D_RZ,
		ST_D_LIM,
		ST_D_LIMW,
		ST_D_ROW,
		ST_D_ZT,
		ST_D_ZTW,
		ST_D_SQ,
		ST_D_XT,
		ST_D_TEST,
		ST_D_UPD,
		ST_P_RD,
		ST_P_CELL,
		ST_P_UPD
	} state_t;

	typedef struct packed {
		logic [CELL_BITS-1:0] rd_addr;
		logic [CELL_BITS-1:0] wr_addr;
		logic                 wr_pend;
		logic                 pend_val;
		logic                 wr_expl;
		logic                 expl_val;
	} flag_req_t;

	typedef struct packed {
		logic pend;
		logic expl;
	} flag_rsp_t;

endpackage

// ===== rtl/ellipse_scan_dedup_queue.sv =====
// Ellipse scan over a 64 x 64 cell grid feeding a de-duplicating FIFO of pending cells.
// Detect: squares the radii and forms the limit, then squares dz per row and dx per cell
// and tests each cell, updating those inside the ellipse and the grid. Disabled grid: done without a scan.
// Process: each dequeued cell is read from the ring, then its flags are read and updated.
// One item at a time; done pulses one cycle, the receiver cannot stall.
// After reset, and after any grid size write, a clearing pass over all 4096 cells keeps busy high.
module ellipse_scan_dedup_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  center_x,
	input  logic [5:0]  center_z,
	input  logic [4:0]  radius_x,
	input  logic [4:0]  radius_z,
	input  logic [12:0] batch_size,
	output logic        done,
	output logic [12:0] count,
	output logic [12:0] queue_level,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	esdq_pkg::state_t state_q, state_d;

	logic [esdq_pkg::CELL_BITS-1:0] clr_addr_q;
	logic                           clr_all_q;
	logic [6:0]                     gw_q, gh_q;
	logic [esdq_pkg::CELL_BITS-1:0] head_q, tail_q;
	logic [esdq_pkg::CNT_BITS-1:0]  qcount_q;
	logic [esdq_pkg::CNT_BITS-1:0]  added_q;
	logic [esdq_pkg::CNT_BITS-1:0]  batch_q;
	logic                           done_q;
	logic [esdq_pkg::CNT_BITS-1:0]  count_q, level_q;

	logic [5:0]        cx_q, cz_q;
	logic [4:0]        rx_q, rz_q;
	logic signed [5:0] dx_q, dz_q;
	logic [9:0]        rx2_q, rz2_q;
	logic [esdq_pkg::PROD_BITS-1:0] lim_q, zt_q;
	logic [esdq_pkg::CELL_BITS-1:0] cell_q;

	logic [esdq_pkg::MUL_BITS-1:0]  mul_a, mul_b;
	logic [esdq_pkg::PROD_BITS-1:0] mul_p;
	esdq_pkg::flag_req_t freq;
	esdq_pkg::flag_rsp_t frsp;
	logic                           ring_we;
	logic [esdq_pkg::CELL_BITS-1:0] ring_rdata;

	logic [4:0]        dx_abs, dz_abs;
	logic signed [7:0] px, pz;
	logic              in_grid, in_ell, hit, last_x, last_z, enq_ok;
	logic [esdq_pkg::PROD_BITS:0] sum;
	logic [esdq_pkg::CELL_BITS-1:0] cell_idx;
	logic [6:0]        cfg_sat;
	esdq_pkg::state_t  adv_state;

	esdq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	esdq_flags u_flags (.clk(clk), .req(freq), .rsp(frsp));
	esdq_ring u_ring (
		.clk(clk), .we(ring_we), .waddr(tail_q), .wdata(cell_q),
		.raddr(head_q), .rdata(ring_rdata)
	);

	assign dx_abs  = dx_q[5] ? 5'(-dx_q) : dx_q[4:0];
	assign dz_abs  = dz_q[5] ? 5'(-dz_q) : dz_q[4:0];
	assign px      = $signed({2'b00, cx_q}) + 8'(dx_q);
	assign pz      = $signed({2'b00, cz_q}) + 8'(dz_q);
	assign in_grid = !px[7] && !pz[7] && (px[6:0] < gw_q) && (pz[6:0] < gh_q);
	assign sum     = {1'b0, mul_p} + {1'b0, zt_q};
	assign in_ell  = sum <= {1'b0, lim_q};
	assign hit     = in_ell && in_grid;
	assign cell_idx = {pz[5:0], px[5:0]};
	assign last_x  = dx_q == $signed({1'b0, rx_q});
	assign last_z  = dz_q == $signed({1'b0, rz_q});
	assign enq_ok  = !frsp.pend && !frsp.expl && !qcount_q[esdq_pkg::CNT_BITS-1];
	assign cfg_sat = (cfg_data > esdq_pkg::GRID_MAX) ? esdq_pkg::GRID_MAX : cfg_data;
	assign adv_state = last_x ? (last_z ? esdq_pkg::ST_IDLE : esdq_pkg::ST_D_ROW)
	                          : esdq_pkg::ST_D_SQ;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			esdq_pkg::ST_CLR:    if (clr_addr_q == esdq_pkg::LAST_CELL) state_d = esdq_pkg::ST_IDLE;
			esdq_pkg::ST_IDLE: begin
				if (start) begin
					if (kind)
						state_d = esdq_pkg::ST_P_RD;
					else if (gw_q != 7'd0 && gh_q != 7'd0)
						state_d = esdq_pkg::ST_D_RX;
				end
			end
			esdq_pkg::ST_D_RX:   state_d = esdq_pkg::ST_D_RZ;
			esdq_pkg::ST_D_RZ:   state_d = esdq_pkg::ST_D_LIM;
			esdq_pkg::ST_D_LIM:  state_d = esdq_pkg::ST_D_LIMW;
			esdq_pkg::ST_D_LIMW: state_d = esdq_pkg::ST_D_ROW;
			esdq_pkg::ST_D_ROW:  state_d = esdq_pkg::ST_D_ZT;
			esdq_pkg::ST_D_ZT:   state_d = esdq_pkg::ST_D_ZTW;
			esdq_pkg::ST_D_ZTW:  state_d = esdq_pkg::ST_D_SQ;
			esdq_pkg::ST_D_SQ:   state_d = esdq_pkg::ST_D_XT;
			esdq_pkg::ST_D_XT:   state_d = esdq_pkg::ST_D_TEST;
			esdq_pkg::ST_D_TEST: state_d = hit ? esdq_pkg::ST_D_UPD : adv_state;
			esdq_pkg::ST_D_UPD:  state_d = adv_state;
			esdq_pkg::ST_P_RD: begin
				if (batch_q == '0 || qcount_q == '0)
					state_d = esdq_pkg::ST_IDLE;
				else
					state_d = esdq_pkg::ST_P_CELL;
			end
			esdq_pkg::ST_P_CELL: state_d = esdq_pkg::ST_P_UPD;
			esdq_pkg::ST_P_UPD:  state_d = esdq_pkg::ST_P_RD;
			default:             state_d = esdq_pkg::ST_IDLE;
		endcase
		if (cfg_we)
			state_d = esdq_pkg::ST_CLR;
	end

	// multiplier operands, memory requests
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		freq.rd_addr = cell_idx;
		freq.wr_addr = cell_q;
		freq.wr_pend = 1'b0;
		freq.pend_val = 1'b0;
		freq.wr_expl = 1'b0;
		freq.expl_val = 1'b0;
		ring_we      = 1'b0;
		unique case (state_q)
			esdq_pkg::ST_CLR: begin
				freq.wr_addr = clr_addr_q;
				freq.wr_pend = 1'b1;
				freq.wr_expl = clr_all_q;
			end
			esdq_pkg::ST_D_RX: begin
				mul_a = {5'd0, rx_q};
				mul_b = {5'd0, rx_q};
			end
			esdq_pkg::ST_D_RZ: begin
				mul_a = {5'd0, rz_q};
				mul_b = {5'd0, rz_q};
			end
			esdq_pkg::ST_D_LIM: begin
				mul_a = rx2_q;
				mul_b = mul_p[9:0];
			end
			esdq_pkg::ST_D_ROW: begin
				mul_a = {5'd0, dz_abs};
				mul_b = {5'd0, dz_abs};
			end
			esdq_pkg::ST_D_ZT: begin
				mul_a = mul_p[9:0];
				mul_b = rx2_q;
			end
			esdq_pkg::ST_D_SQ: begin
				mul_a = {5'd0, dx_abs};
				mul_b = {5'd0, dx_abs};
			end
			esdq_pkg::ST_D_XT: begin
				mul_a = mul_p[9:0];
				mul_b = rz2_q;
			end
			esdq_pkg::ST_D_UPD: begin
				freq.wr_pend  = enq_ok;
				freq.pend_val = 1'b1;
				ring_we       = enq_ok;
			end
			esdq_pkg::ST_P_CELL: freq.rd_addr = ring_rdata;
			esdq_pkg::ST_P_UPD: begin
				freq.wr_pend  = 1'b1;
				freq.wr_expl  = 1'b1;
				freq.expl_val = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= esdq_pkg::ST_CLR;
			clr_addr_q <= '0;
			clr_all_q  <= 1'b1;
			gw_q       <= esdq_pkg::GRID_MAX;
			gh_q       <= esdq_pkg::GRID_MAX;
			head_q     <= '0;
			tail_q     <= '0;
			qcount_q   <= '0;
			added_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == esdq_pkg::ST_CLR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == esdq_pkg::LAST_CELL)
					clr_all_q <= 1'b0;
			end
			if (state_q == esdq_pkg::ST_IDLE && start && !cfg_we)
				added_q <= '0;
			if (state_q == esdq_pkg::ST_D_UPD && enq_ok) begin
				tail_q   <= tail_q + 1'b1;
				qcount_q <= qcount_q + 1'b1;
				added_q  <= added_q + 1'b1;
			end
			if (state_q == esdq_pkg::ST_P_CELL) begin
				head_q   <= head_q + 1'b1;
				qcount_q <= qcount_q - 1'b1;
			end
			if (state_q == esdq_pkg::ST_P_UPD && !frsp.expl)
				added_q <= added_q + 1'b1;
			// report when a scan or process state drops back to idle
			if (state_q != esdq_pkg::ST_CLR && state_q != esdq_pkg::ST_IDLE &&
			    state_d == esdq_pkg::ST_IDLE)
				done_q <= 1'b1;
			if (state_q == esdq_pkg::ST_IDLE && start && !kind && !cfg_we &&
			    (gw_q == 7'd0 || gh_q == 7'd0))
				done_q <= 1'b1;
			if (cfg_we) begin
				if (cfg_index == esdq_pkg::REG_GRID_WIDTH)
					gw_q <= cfg_sat;
				else
					gh_q <= cfg_sat;
				clr_addr_q <= '0;
				head_q     <= '0;
				tail_q     <= '0;
				qcount_q   <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			esdq_pkg::ST_IDLE: begin
				cx_q    <= center_x;
				cz_q    <= center_z;
				rx_q    <= radius_x;
				rz_q    <= radius_z;
				dz_q    <= -$signed({1'b0, radius_z});
				batch_q <= batch_size;
			end
			esdq_pkg::ST_D_RZ:   rx2_q <= mul_p[9:0];
			esdq_pkg::ST_D_LIM:  rz2_q <= mul_p[9:0];
			esdq_pkg::ST_D_LIMW: lim_q <= mul_p;
			esdq_pkg::ST_D_ZTW: begin
				zt_q <= mul_p;
				dx_q <= -$signed({1'b0, rx_q});
			end
			esdq_pkg::ST_D_TEST: begin
				cell_q <= cell_idx;
				if (!hit) begin
					if (!last_x)
						dx_q <= dx_q + 6'sd1;
					else if (!last_z)
						dz_q <= dz_q + 6'sd1;
				end
			end
			esdq_pkg::ST_D_UPD: begin
				if (!last_x)
					dx_q <= dx_q + 6'sd1;
				else if (!last_z)
					dz_q <= dz_q + 6'sd1;
			end
			esdq_pkg::ST_P_CELL: begin
				cell_q  <= ring_rdata;
				batch_q <= batch_q - 1'b1;
			end
			default: ;
		endcase
	end

	// hold the result for the one-cycle strobe
	always_ff @(posedge clk) begin
		if (state_q == esdq_pkg::ST_IDLE) begin
			count_q <= '0;
		end else begin
			count_q <= added_q + {12'd0, (state_q == esdq_pkg::ST_D_UPD && enq_ok) ||
			                             (state_q == esdq_pkg::ST_P_UPD && !frsp.expl)};
		end
		level_q <= qcount_q + {12'd0, state_q == esdq_pkg::ST_D_UPD && enq_ok}
		                    - {12'd0, state_q == esdq_pkg::ST_P_CELL};
	end

	assign busy        = state_q != esdq_pkg::ST_IDLE;
	assign done        = done_q;
	assign count       = count_q;
	assign queue_level = level_q;

endmodule

// ===== rtl/esdq_mul.sv =====
// Shared 10 x 10 unsigned multiplier with a registered product.
// Depends on esdq_pkg.
module esdq_mul (
	input  logic                            clk,
	input  logic [esdq_pkg::MUL_BITS-1:0]   a,
	input  logic [esdq_pkg::MUL_BITS-1:0]   b,
	output logic [esdq_pkg::PROD_BITS-1:0]  p
);

	logic [esdq_pkg::PROD_BITS-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/esdq_flags.sv =====
// Pending and explored flag stores, one bit per cell, registered reads.
// Depends on esdq_pkg.
module esdq_flags (
	input  logic                clk,
	input  esdq_pkg::flag_req_t req,
	output esdq_pkg::flag_rsp_t rsp
);

	logic pend_mem [esdq_pkg::CELLS];
	logic expl_mem [esdq_pkg::CELLS];
	logic pend_q;
	logic expl_q;

	always_ff @(posedge clk) begin
		if (req.wr_pend) begin
			pend_mem[req.wr_addr] <= req.pend_val;
		end
		pend_q <= pend_mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.wr_expl) begin
			expl_mem[req.wr_addr] <= req.expl_val;
		end
		expl_q <= expl_mem[req.rd_addr];
	end

	assign rsp.pend = pend_q;
	assign rsp.expl = expl_q;

endmodule

// ===== rtl/esdq_ring.sv =====
// Ring store of pending cell numbers: written at the tail, read at the head.
// Depends on esdq_pkg.
module esdq_ring (
	input  logic                              clk,
	input  logic                              we,
	input  logic [esdq_pkg::CELL_BITS-1:0]    waddr,
	input  logic [esdq_pkg::CELL_BITS-1:0]    wdata,
	input  logic [esdq_pkg::CELL_BITS-1:0]    raddr,
	output logic [esdq_pkg::CELL_BITS-1:0]    rdata
);

	logic [esdq_pkg::CELL_BITS-1:0] mem [esdq_pkg::CELLS];
	logic [esdq_pkg::CELL_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
